@@ src/mgj_pkg.sv @@
// ----------------------------------------------------------------------------
// mgj_pkg
// Shared types and constants for the Gauss-Jordan matrix inversion block.
// ----------------------------------------------------------------------------
package mgj_pkg;

  localparam int DATA_W    = 32;
  localparam int DIM_W     = 4;
  localparam int THR_W     = 31;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd1;

  // result status codes
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_SINGULAR = 1'b1;

  // reset values of the configuration registers
  localparam logic [DIM_W-1:0] DIMENSION_RESET = 4'd4;
  localparam logic [THR_W-1:0] THRESHOLD_RESET = 31'd7;

  // sequencer states
  typedef enum logic [4:0] {
    S_LOAD, S_INIT, S_COL, S_SCAN, S_CHECK,
    S_SWA, S_SWB, S_SWC, S_SWD,
    S_PIV, S_PIVL, S_KCHK, S_FDIV, S_FWAIT,
    S_ERP, S_ERX, S_EM1, S_EM2, S_EM3,
    S_NRD, S_NDW, S_NDWW, S_NDIW,
    S_ORD, S_OLD, S_SING, S_OWAIT
  } mgj_state_t;

endpackage

@@ src/mgj_in_if.sv @@
// ----------------------------------------------------------------------------
// mgj_in_if
// Input element channel: one matrix element per transfer.
// ----------------------------------------------------------------------------
interface mgj_in_if import mgj_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] element_in;

  modport source (output valid, element_in, input ready);
  modport sink (input valid, element_in, output ready);
endinterface

@@ src/mgj_out_if.sv @@
// ----------------------------------------------------------------------------
// mgj_out_if
// Result channel: one inverse element or a singular report per transfer.
// ----------------------------------------------------------------------------
interface mgj_out_if import mgj_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] element_out;
  logic                     status;
  logic                     last;

  modport source (output valid, element_out, status, last, input ready);
  modport sink (input valid, element_out, status, last, output ready);
endinterface

@@ src/mgj_cfg_if.sv @@
// ----------------------------------------------------------------------------
// mgj_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface mgj_cfg_if import mgj_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ src/mgj_div.sv @@
// ----------------------------------------------------------------------------
// mgj_div
// Bit-serial fixed point divider, rounds half away from zero, saturates.
// ----------------------------------------------------------------------------
module mgj_div import mgj_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  output logic                     done,
  output logic signed [DATA_W-1:0] q
);

  localparam int NW = DATA_W + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [DATA_W-1:0] ua, ub;
  logic [NW-1:0]     num;
  logic [NW-1:0]     quo;
  logic [DATA_W-1:0] rem;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   rem_sub;
  logic [DATA_W-1:0] divisor;
  logic [CW-1:0]     cnt;
  logic              busy;
  logic              neg;

  // operand magnitudes
  assign ua = a[DATA_W-1] ? (~a + 1'b1) : a;
  assign ub = b[DATA_W-1] ? (~b + 1'b1) : b;

  // one restoring step per cycle
  assign rem_sh  = {rem, num[NW-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        cnt     <= '0;
        num     <= ({{FRAC_BITS{1'b0}}, ua} << FRAC_BITS) + NW'(ub >> 1);
        divisor <= ub;
        rem     <= '0;
        quo     <= '0;
        neg     <= a[DATA_W-1] ^ b[DATA_W-1];
      end else if (busy) begin
        num <= num << 1;
        if (!rem_sub[DATA_W]) begin
          rem <= rem_sub[DATA_W-1:0];
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          rem <= rem_sh[DATA_W-1:0];
          quo <= {quo[NW-2:0], 1'b0};
        end
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  // sign and saturation
  always_comb begin
    if (neg) begin
      if (quo > NW'(64'h8000_0000)) q = {1'b1, {(DATA_W-1){1'b0}}};
      else q = DATA_W'(~quo + 1'b1);
    end else begin
      if (quo > NW'(64'h7FFF_FFFF)) q = {1'b0, {(DATA_W-1){1'b1}}};
      else q = DATA_W'(quo);
    end
  end

endmodule

@@ src/mgj_mulsub.sv @@
// ----------------------------------------------------------------------------
// mgj_mulsub
// Shared multiplier with rounding, saturation and saturating subtract.
// ----------------------------------------------------------------------------
module mgj_mulsub import mgj_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  input  logic signed [DATA_W-1:0] x,
  output logic signed [DATA_W-1:0] res
);

  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] MAXV = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] MINV = -64'sh0000_0000_8000_0000;

  logic signed [63:0]     prod;
  logic signed [DATA_W-1:0] x_q;
  logic signed [63:0]     sh;
  logic signed [DATA_W-1:0] m;
  logic signed [DATA_W:0] d;

  // product stage
  always_ff @(posedge clk) begin
    prod <= a * b;
    x_q  <= x;
  end

  // round, clamp, subtract, clamp
  always_comb begin
    sh = (prod + HALF) >>> FRAC_BITS;
    if (sh > MAXV) m = MAXV[DATA_W-1:0];
    else if (sh < MINV) m = MINV[DATA_W-1:0];
    else m = sh[DATA_W-1:0];
    d = {x_q[DATA_W-1], x_q} - {m[DATA_W-1], m};
    if (d[DATA_W] != d[DATA_W-1]) res = d[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                                  : {1'b0, {(DATA_W-1){1'b1}}};
    else res = d[DATA_W-1:0];
  end

endmodule

@@ src/matrix_inverse_gauss_jordan.sv @@
// ----------------------------------------------------------------------------
// matrix_inverse_gauss_jordan
// Gauss-Jordan inversion with partial pivoting over signed fixed point.
// ----------------------------------------------------------------------------
// Loading takes one element per cycle; the block then stays busy with the
// bit-serial divider (n*(n-1) factors plus 2*n*n normalizations) and the
// shared multiplier (each element update steps through S_ERP, S_ERX,
// S_EM1, S_EM2 and S_EM3). A result is held in S_OWAIT until taken. Reset
// is synchronous and restores dimension 4, threshold 7 and load position
// 0; the matrix stores need no clearing.
module matrix_inverse_gauss_jordan import mgj_pkg::*; #(
  parameter int MAX_DIM   = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  mgj_in_if.sink       item_in,
  mgj_out_if.source    result_out,
  mgj_cfg_if.sink      cfg
);

  localparam int IW    = $clog2(MAX_DIM);
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam logic signed [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

  mgj_state_t state, state_next;

  logic [DIM_W-1:0] dimension;
  logic [THR_W-1:0] threshold;
  logic [IW-1:0]    nm1;

  logic [IW-1:0] i_col, jr, k_row, prow, lrow, lcol;
  logic [DATA_W-1:0] best;
  logic signed [DATA_W-1:0] p, f, pw, piv_inv, xi;

  logic signed [DATA_W-1:0] work_mem [DEPTH];
  logic signed [DATA_W-1:0] inv_mem  [DEPTH];
  logic signed [DATA_W-1:0] rw, ri;
  logic [AW-1:0] raddr, waddr;
  logic work_we, inv_we;
  logic signed [DATA_W-1:0] work_wdata, inv_wdata;
  logic [DATA_W-1:0] rw_mag;

  logic div_start, div_done;
  logic signed [DATA_W-1:0] div_a, div_b, div_q;
  logic signed [DATA_W-1:0] mul_b, mul_x, mul_res;

  logic out_valid, out_status, out_last;
  logic signed [DATA_W-1:0] out_data;

  function automatic logic [AW-1:0] addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return AW'(r) * AW'(MAX_DIM) + AW'(c);
  endfunction

  // effective order minus one
  always_comb begin
    if (dimension == '0) nm1 = '0;
    else if (dimension > DIM_W'(MAX_DIM)) nm1 = IW'(MAX_DIM - 1);
    else nm1 = IW'(dimension - 1'b1);
  end

  assign rw_mag = rw[DATA_W-1] ? (~rw + 1'b1) : rw;

  // matrix stores
  always_ff @(posedge clk) begin
    if (work_we) work_mem[waddr] <= work_wdata;
    if (inv_we) inv_mem[waddr] <= inv_wdata;
    rw <= work_mem[raddr];
    ri <= inv_mem[raddr];
  end

  mgj_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .a(div_a), .b(div_b),
    .done(div_done), .q(div_q)
  );

  mgj_mulsub #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk(clk), .a(f), .b(mul_b), .x(mul_x), .res(mul_res)
  );

  // port drive
  assign item_in.ready          = (state == S_LOAD);
  assign cfg.ready              = 1'b1;
  assign result_out.valid       = out_valid;
  assign result_out.element_out = out_data;
  assign result_out.status      = out_status;
  assign result_out.last        = out_last;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_LOAD;
    else state <= state_next;
  end

  // next state and datapath controls
  always_comb begin
    state_next = state;
    raddr      = '0;
    waddr      = '0;
    work_we    = 1'b0;
    inv_we     = 1'b0;
    work_wdata = rw;
    inv_wdata  = ri;
    div_start  = 1'b0;
    div_a      = rw;
    div_b      = p;
    mul_b      = pw;
    mul_x      = rw;
    case (state)
      S_LOAD: begin
        waddr      = addr(lrow, lcol);
        work_wdata = item_in.element_in;
        if (item_in.valid) begin
          work_we = 1'b1;
          if (lrow == nm1 && lcol == nm1) state_next = S_INIT;
        end
      end
      S_INIT: begin
        inv_we    = 1'b1;
        waddr     = addr(k_row, jr);
        inv_wdata = (k_row == jr) ? ONE : '0;
        if (k_row == nm1 && jr == nm1) state_next = S_COL;
      end
      S_COL: begin
        raddr      = addr(i_col, i_col);
        state_next = S_SCAN;
      end
      S_SCAN: begin
        raddr = addr(jr + 1'b1, i_col);
        if (jr == nm1) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (best < {1'b0, threshold} || best == '0) state_next = S_SING;
        else if (prow != i_col) state_next = S_SWA;
        else state_next = S_PIV;
      end
      S_SWA: begin
        raddr      = addr(i_col, jr);
        state_next = S_SWB;
      end
      S_SWB: begin
        raddr      = addr(prow, jr);
        state_next = S_SWC;
      end
      S_SWC: begin
        waddr      = addr(i_col, jr);
        work_we    = 1'b1;
        inv_we     = 1'b1;
        state_next = S_SWD;
      end
      S_SWD: begin
        waddr      = addr(prow, jr);
        work_we    = 1'b1;
        inv_we     = 1'b1;
        work_wdata = pw;
        inv_wdata  = piv_inv;
        state_next = (jr == nm1) ? S_PIV : S_SWA;
      end
      S_PIV: begin
        raddr      = addr(i_col, i_col);
        state_next = S_PIVL;
      end
      S_PIVL: state_next = S_KCHK;
      S_KCHK: begin
        raddr = addr(k_row, i_col);
        if (k_row == i_col) begin
          if (k_row == nm1) state_next = S_NRD;
        end else begin
          state_next = S_FDIV;
        end
      end
      S_FDIV: begin
        div_start  = 1'b1;
        state_next = S_FWAIT;
      end
      S_FWAIT: if (div_done) state_next = S_ERP;
      S_ERP: begin
        raddr      = addr(i_col, jr);
        state_next = S_ERX;
      end
      S_ERX: begin
        raddr      = addr(k_row, jr);
        state_next = S_EM1;
      end
      S_EM1: state_next = S_EM2;
      S_EM2: begin
        waddr      = addr(k_row, jr);
        work_we    = 1'b1;
        work_wdata = mul_res;
        mul_b      = piv_inv;
        mul_x      = xi;
        state_next = S_EM3;
      end
      S_EM3: begin
        waddr     = addr(k_row, jr);
        inv_we    = 1'b1;
        inv_wdata = mul_res;
        if (jr == nm1) state_next = (k_row == nm1) ? S_NRD : S_KCHK;
        else state_next = S_ERP;
      end
      S_NRD: begin
        raddr      = addr(i_col, jr);
        state_next = S_NDW;
      end
      S_NDW: begin
        div_start  = 1'b1;
        state_next = S_NDWW;
      end
      S_NDWW: begin
        waddr      = addr(i_col, jr);
        work_wdata = div_q;
        div_a      = xi;
        if (div_done) begin
          work_we    = 1'b1;
          div_start  = 1'b1;
          state_next = S_NDIW;
        end
      end
      S_NDIW: begin
        waddr     = addr(i_col, jr);
        inv_wdata = div_q;
        if (div_done) begin
          inv_we = 1'b1;
          if (jr == nm1) state_next = (i_col == nm1) ? S_ORD : S_COL;
          else state_next = S_NRD;
        end
      end
      S_ORD: begin
        raddr      = addr(k_row, jr);
        state_next = S_OLD;
      end
      S_OLD: state_next = S_OWAIT;
      S_SING: state_next = S_OWAIT;
      S_OWAIT: begin
        if (result_out.ready) state_next = out_last ? S_LOAD : S_ORD;
      end
      default: state_next = S_LOAD;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dimension <= DIMENSION_RESET;
      threshold <= THRESHOLD_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_DIMENSION: dimension <= cfg.data[DIM_W-1:0];
        CFG_THRESHOLD: threshold <= cfg.data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // load counters
  always_ff @(posedge clk) begin
    if (rst || (cfg.valid && cfg.index == CFG_DIMENSION)) begin
      lrow <= '0;
      lcol <= '0;
    end else if (state == S_LOAD && item_in.valid) begin
      if (lcol == nm1) begin
        lcol <= '0;
        lrow <= (lrow == nm1) ? '0 : lrow + 1'b1;
      end else begin
        lcol <= lcol + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_OLD: begin
          out_valid  <= 1'b1;
          out_data   <= ri;
          out_status <= STATUS_OK;
          out_last   <= (k_row == nm1) && (jr == nm1);
        end
        S_SING: begin
          out_valid  <= 1'b1;
          out_data   <= '0;
          out_status <= STATUS_SINGULAR;
          out_last   <= 1'b1;
        end
        S_OWAIT: if (result_out.ready) out_valid <= 1'b0;
        default: ;
      endcase
    end
  end

  // sequencer counters and operand registers
  always_ff @(posedge clk) begin
    case (state)
      S_LOAD: begin
        k_row <= '0;
        jr    <= '0;
      end
      S_INIT: begin
        if (jr == nm1) begin
          jr    <= '0;
          k_row <= k_row + 1'b1;
        end else begin
          jr <= jr + 1'b1;
        end
        i_col <= '0;
      end
      S_COL: begin
        jr   <= i_col;
        best <= '0;
        prow <= i_col;
      end
      S_SCAN: begin
        if (rw_mag > best) begin
          best <= rw_mag;
          prow <= jr;
        end
        jr <= jr + 1'b1;
      end
      S_CHECK: jr <= '0;
      S_SWB: begin
        pw      <= rw;
        piv_inv <= ri;
      end
      S_SWD: jr <= jr + 1'b1;
      S_PIVL: begin
        p     <= rw;
        k_row <= '0;
      end
      S_KCHK: begin
        jr <= '0;
        if (k_row == i_col && k_row != nm1) k_row <= k_row + 1'b1;
      end
      S_FWAIT: begin
        if (div_done) begin
          f  <= div_q;
          jr <= '0;
        end
      end
      S_ERX: begin
        pw      <= rw;
        piv_inv <= ri;
      end
      S_EM1: xi <= ri;
      S_EM3: begin
        if (jr == nm1) begin
          jr    <= '0;
          k_row <= k_row + 1'b1;
        end else begin
          jr <= jr + 1'b1;
        end
      end
      S_NDW: xi <= ri;
      S_NDIW: begin
        if (div_done) begin
          if (jr == nm1) begin
            jr    <= '0;
            k_row <= '0;
            i_col <= i_col + 1'b1;
          end else begin
            jr <= jr + 1'b1;
          end
        end
      end
      S_OWAIT: begin
        if (result_out.ready) begin
          if (jr == nm1) begin
            jr    <= '0;
            k_row <= k_row + 1'b1;
          end else begin
            jr <= jr + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

@@ src/mgj_checker.sv @@
// ----------------------------------------------------------------------------
// mgj_checker
// Port-level checks of the inversion block, bound to the top level.
// ----------------------------------------------------------------------------
module mgj_checker import mgj_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] out_element,
  input logic                     out_status,
  input logic                     out_last
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_element) && $stable(out_last))
    else $error("stalled result changed");

  // no input is taken while a result is pending
  assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input ready while result pending");

  // a singular report is the only and final result
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == STATUS_SINGULAR |-> out_last && out_element == '0)
    else $error("malformed singular report");

  // after the final transfer the block is ready for a new matrix
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_last |=> in_ready)
    else $error("not ready after final result");

endmodule

bind matrix_inverse_gauss_jordan mgj_checker u_mgj_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(item_in.ready),
  .out_valid(result_out.valid),
  .out_ready(result_out.ready),
  .out_element(result_out.element_out),
  .out_status(result_out.status),
  .out_last(result_out.last)
);
